### hw/rtl/fxq_alu_pkg.sv
`timescale 1ns / 1ps

package fxq_alu_pkg;

    localparam int FRAC_BITS = 8;
    localparam int DATA_W    = 32;
    localparam int OP_W      = 4;
    localparam int STATUS_W  = 2;
    // Products and saturation inputs are carried as 64-bit magnitudes.
    localparam int MAG_W     = 2 * DATA_W;
    // Divisor is 2*|b|, remainder stays below it.
    localparam int DEN_W     = DATA_W + 1;
    // Numerator 2*(|a| << F) + |b|; one quotient bit per pipeline step.
    localparam int NUM_W     = DATA_W + 1 + FRAC_BITS;
    localparam int IN_TDATA_W  = 2 * DATA_W;
    localparam int OUT_TDATA_W = ((DATA_W + 1 + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - DATA_W - 1;

    typedef enum logic [OP_W-1:0] {
        OP_ADD     = 4'd0,
        OP_SUB     = 4'd1,
        OP_MUL     = 4'd2,
        OP_DIV     = 4'd3,
        OP_GT      = 4'd4,
        OP_LT      = 4'd5,
        OP_LE      = 4'd6,
        OP_GE      = 4'd7,
        OP_EQ      = 4'd8,
        OP_NE      = 4'd9,
        OP_INC     = 4'd10,
        OP_DEC     = 4'd11,
        OP_MIN     = 4'd12,
        OP_MAX     = 4'd13,
        OP_TOINT   = 4'd14,
        OP_FROMINT = 4'd15
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_DIV_ZERO = 2'd2
    } status_t;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        status_t           status;
    } sat_t;

    // One item in flight through the divider pipeline.
    typedef struct packed {
        logic              is_div;
        logic              is_mul;
        logic              neg;
        logic [DATA_W-1:0] result;
        logic              truth;
        status_t           status;
        logic [DEN_W-1:0]  den;
        logic [DEN_W-1:0]  rem;
        logic [NUM_W-1:0]  num;
        logic [NUM_W-1:0]  quo;
    } lane_t;

    function automatic logic [DATA_W-1:0] magnitude(input logic [DATA_W-1:0] v);
        magnitude = v[DATA_W-1] ? (DATA_W'(0) - v) : v;
    endfunction

    // Sign and magnitude to a saturated two's-complement word.
    function automatic sat_t from_signmag(input logic neg, input logic [MAG_W-1:0] mag);
        sat_t             r;
        logic [MAG_W-1:0] lim;
        logic [MAG_W-1:0] m;
        lim = MAG_W'(1) << (DATA_W - 1);
        if (!neg) begin
            lim = lim - MAG_W'(1);
        end
        m = mag;
        r.status = ST_OK;
        if (mag > lim) begin
            m = lim;
            r.status = ST_OVERFLOW;
        end
        r.value = neg ? (DATA_W'(0) - m[DATA_W-1:0]) : m[DATA_W-1:0];
        return r;
    endfunction

    // Saturate a sum that grew by one bit.
    function automatic sat_t sat_sum(input logic [DATA_W:0] v);
        logic [DATA_W:0] mag;
        mag = v[DATA_W] ? ((DATA_W + 1)'(0) - v) : v;
        return from_signmag(v[DATA_W], MAG_W'(mag));
    endfunction

endpackage

### hw/rtl/fixed_point_q24_8_alu.sv
`timescale 1ns / 1ps

// Signed Q24.8 fixed-point ALU, no kept state.
// Input channel (s_): s_tuser carries the operation code, s_tdata carries
// operand_a in bits 31:0 and operand_b in bits 63:32. A transaction is taken
// when s_tvalid and s_tready are both high.
// Result channel (m_): m_tdata carries result in bits 31:0 and truth in bit 32,
// m_tuser carries status (0 ok, 1 saturated, 2 divide by zero).
// Every operation walks the same pipeline: input register, decode/execute
// stage, 41 divider steps (one quotient bit each, multiply uses the first two
// steps for product and rounding) and the output register.
// Throughput is one transaction per cycle; results leave in input order.
// When the receiver holds m_tready low with a result waiting, the whole
// pipeline freezes and s_tready drops; nothing is lost or repeated, and the
// block keeps taking transactions while the output slot is empty or drains.
// Reset (aresetn low, synchronous) clears every valid bit; in-flight
// transactions are discarded.
module fixed_point_q24_8_alu (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [fxq_alu_pkg::IN_TDATA_W-1:0]    s_tdata,   // operand_a, operand_b
    input  logic [fxq_alu_pkg::OP_W-1:0]          s_tuser,   // operation
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [fxq_alu_pkg::OUT_TDATA_W-1:0]   m_tdata,   // result, truth, zero pad
    output logic [fxq_alu_pkg::STATUS_W-1:0]      m_tuser    // status
);

    localparam int DATA_W = fxq_alu_pkg::DATA_W;
    localparam int MAG_W  = fxq_alu_pkg::MAG_W;
    localparam int DEN_W  = fxq_alu_pkg::DEN_W;
    localparam int NUM_W  = fxq_alu_pkg::NUM_W;
    localparam int FRAC   = fxq_alu_pkg::FRAC_BITS;

    logic adv;

    // input register
    logic                  in_vld_reg;
    fxq_alu_pkg::op_t      op_reg;
    logic [DATA_W-1:0]     a_reg;
    logic [DATA_W-1:0]     b_reg;

    // execute stage
    logic                  st1_vld_reg;
    fxq_alu_pkg::lane_t    st1_reg;
    fxq_alu_pkg::lane_t    st1_next;
    logic [DATA_W-1:0]     ma_reg;
    logic [DATA_W-1:0]     mb_reg;
    logic [DATA_W-1:0]     ma_next;
    logic [DATA_W-1:0]     mb_next;

    logic [MAG_W-1:0]      prod_reg;
    logic [MAG_W-1:0]      mul_round;
    fxq_alu_pkg::sat_t     mul_sat;

    logic                  pipe_vld_reg [NUM_W];
    fxq_alu_pkg::lane_t    pipe_reg     [NUM_W];

    logic                  m_tvalid_reg;
    logic [DATA_W-1:0]     out_res_reg;
    logic                  out_truth_reg;
    fxq_alu_pkg::status_t  out_status_reg;
    logic [DATA_W-1:0]     out_res_next;
    fxq_alu_pkg::status_t  out_status_next;
    fxq_alu_pkg::sat_t     div_sat;
    fxq_alu_pkg::lane_t    last;

    fxq_alu_pkg::sat_t     sat_x;
    logic [DATA_W:0]       a_ext;
    logic [DATA_W:0]       b_ext;

    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (adv) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            op_reg <= fxq_alu_pkg::op_t'(s_tuser);
            a_reg  <= s_tdata[DATA_W-1:0];
            b_reg  <= s_tdata[2*DATA_W-1:DATA_W];
        end
    end

    // Decode and execute everything except multiply and divide.
    assign a_ext = {a_reg[DATA_W-1], a_reg};
    assign b_ext = {b_reg[DATA_W-1], b_reg};

    always_comb begin
        ma_next = fxq_alu_pkg::magnitude(a_reg);
        mb_next = fxq_alu_pkg::magnitude(b_reg);
        sat_x   = '0;

        st1_next        = '0;
        st1_next.neg    = a_reg[DATA_W-1] ^ b_reg[DATA_W-1];
        st1_next.status = fxq_alu_pkg::ST_OK;
        st1_next.den    = {mb_next, 1'b0};
        st1_next.num    = (NUM_W'(ma_next) << (FRAC + 1)) + NUM_W'(mb_next);

        unique case (op_reg)
            fxq_alu_pkg::OP_ADD: begin
                sat_x = fxq_alu_pkg::sat_sum(a_ext + b_ext);
                st1_next.result = sat_x.value;
                st1_next.status = sat_x.status;
            end
            fxq_alu_pkg::OP_SUB: begin
                sat_x = fxq_alu_pkg::sat_sum(a_ext - b_ext);
                st1_next.result = sat_x.value;
                st1_next.status = sat_x.status;
            end
            fxq_alu_pkg::OP_MUL: begin
                st1_next.is_mul = 1'b1;
            end
            fxq_alu_pkg::OP_DIV: begin
                if (mb_next == '0) begin
                    st1_next.status = fxq_alu_pkg::ST_DIV_ZERO;
                end else begin
                    st1_next.is_div = 1'b1;
                end
            end
            fxq_alu_pkg::OP_GT: st1_next.truth = $signed(a_reg) >  $signed(b_reg);
            fxq_alu_pkg::OP_LT: st1_next.truth = $signed(a_reg) <  $signed(b_reg);
            fxq_alu_pkg::OP_LE: st1_next.truth = $signed(a_reg) <= $signed(b_reg);
            fxq_alu_pkg::OP_GE: st1_next.truth = $signed(a_reg) >= $signed(b_reg);
            fxq_alu_pkg::OP_EQ: st1_next.truth = a_reg == b_reg;
            fxq_alu_pkg::OP_NE: st1_next.truth = a_reg != b_reg;
            fxq_alu_pkg::OP_INC: begin
                sat_x = fxq_alu_pkg::sat_sum(a_ext + (DATA_W + 1)'(1));
                st1_next.result = sat_x.value;
                st1_next.status = sat_x.status;
            end
            fxq_alu_pkg::OP_DEC: begin
                sat_x = fxq_alu_pkg::sat_sum(a_ext - (DATA_W + 1)'(1));
                st1_next.result = sat_x.value;
                st1_next.status = sat_x.status;
            end
            fxq_alu_pkg::OP_MIN: begin
                st1_next.result = ($signed(a_reg) > $signed(b_reg)) ? b_reg : a_reg;
            end
            fxq_alu_pkg::OP_MAX: begin
                st1_next.result = ($signed(a_reg) > $signed(b_reg)) ? a_reg : b_reg;
            end
            fxq_alu_pkg::OP_TOINT: begin
                sat_x = fxq_alu_pkg::from_signmag(a_reg[DATA_W-1], MAG_W'(ma_next >> FRAC));
                st1_next.result = sat_x.value;
                st1_next.status = sat_x.status;
            end
            fxq_alu_pkg::OP_FROMINT: begin
                sat_x = fxq_alu_pkg::from_signmag(a_reg[DATA_W-1],
                                                  MAG_W'(ma_next) << FRAC);
                st1_next.result = sat_x.value;
                st1_next.status = sat_x.status;
            end
            default: begin
                st1_next.result = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_vld_reg <= 1'b0;
        end else if (adv) begin
            st1_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            st1_reg <= st1_next;
            ma_reg  <= ma_next;
            mb_reg  <= mb_next;
        end
    end

    // Product lines up with divider step 0, rounding with step 1.
    always_ff @(posedge aclk) begin
        if (adv) begin
            prod_reg <= MAG_W'(ma_reg) * MAG_W'(mb_reg);
        end
    end

    assign mul_round = (prod_reg + (MAG_W'(1) << (FRAC - 1))) >> FRAC;
    assign mul_sat   = fxq_alu_pkg::from_signmag(pipe_reg[0].neg, mul_round);

    // Restoring divider, one quotient bit per stage, MSB first.
    for (genvar k = 0; k < NUM_W; k++) begin : g_div
        fxq_alu_pkg::lane_t prev;
        fxq_alu_pkg::lane_t nxt;
        logic               prev_vld;
        logic [DEN_W:0]     shifted;

        if (k == 0) begin : g_first
            assign prev     = st1_reg;
            assign prev_vld = st1_vld_reg;
        end else begin : g_next
            assign prev     = pipe_reg[k-1];
            assign prev_vld = pipe_vld_reg[k-1];
        end

        always_comb begin
            nxt     = prev;
            shifted = {prev.rem, prev.num[NUM_W-1-k]};
            if (shifted >= {1'b0, prev.den}) begin
                nxt.rem              = DEN_W'(shifted - {1'b0, prev.den});
                nxt.quo[NUM_W-1-k]   = 1'b1;
            end else begin
                nxt.rem = shifted[DEN_W-1:0];
            end
            if (k == 1 && prev.is_mul) begin
                nxt.result = mul_sat.value;
                nxt.status = mul_sat.status;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                pipe_vld_reg[k] <= 1'b0;
            end else if (adv) begin
                pipe_vld_reg[k] <= prev_vld;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                pipe_reg[k] <= nxt;
            end
        end
    end

    // Final saturation of the quotient, then the output register.
    assign last    = pipe_reg[NUM_W-1];
    assign div_sat = fxq_alu_pkg::from_signmag(last.neg, MAG_W'(last.quo));

    always_comb begin
        if (last.is_div) begin
            out_res_next    = div_sat.value;
            out_status_next = div_sat.status;
        end else begin
            out_res_next    = last.result;
            out_status_next = last.status;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            m_tvalid_reg <= pipe_vld_reg[NUM_W-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_res_reg    <= out_res_next;
            out_truth_reg  <= last.truth;
            out_status_reg <= out_status_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{fxq_alu_pkg::OUT_PAD_W{1'b0}}, out_truth_reg, out_res_reg};
    assign m_tuser  = out_status_reg;

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int DATA_W      = fxq_alu_pkg::DATA_W;
    localparam int FRAC_BITS   = fxq_alu_pkg::FRAC_BITS;
    localparam int IN_TDATA_W  = fxq_alu_pkg::IN_TDATA_W;
    localparam int OUT_TDATA_W = fxq_alu_pkg::OUT_TDATA_W;
    localparam int OP_W        = fxq_alu_pkg::OP_W;
    localparam int STATUS_W    = fxq_alu_pkg::STATUS_W;

    localparam logic [DATA_W-1:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] Q_MIN = 32'h8000_0000;
    localparam logic [DATA_W-1:0] Q_ONE = 32'd256;
    localparam int RANDOM_ITEMS = 1625;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 1_000_000;

    typedef struct packed {
        logic [DATA_W-1:0]    result;
        logic                 truth;
        fxq_alu_pkg::status_t status;
    } alu_out_t;

    typedef struct packed {
        fxq_alu_pkg::op_t  op;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic              known;
        alu_out_t          want;
    } dir_row_t;

    logic                    aclk;
    logic                    aresetn;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [IN_TDATA_W-1:0]   s_tdata;
    logic [OP_W-1:0]         s_tuser;
    logic                    m_tvalid;
    logic                    m_tready;
    logic [OUT_TDATA_W-1:0]  m_tdata;
    logic [STATUS_W-1:0]     m_tuser;

    alu_out_t expected_results[$];
    dir_row_t directed_rows[$];
    int       mismatch_count = 0;
    int       results_seen   = 0;
    int       cycle_count    = 0;
    bit       calm           = 1'b0;
    bit       long_hold      = 1'b0;

    fixed_point_q24_8_alu dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    // Sign and magnitude to a saturated word.
    function automatic alu_out_t q24_clamp(input bit neg, input logic [63:0] mag);
        alu_out_t         r;
        logic [63:0]      lim;
        logic [63:0]      m;
        lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
        m = mag;
        r.truth = 1'b0;
        r.status = fxq_alu_pkg::ST_OK;
        if (m > lim) begin
            m = lim;
            r.status = fxq_alu_pkg::ST_OVERFLOW;
        end
        r.result = neg ? DATA_W'(64'd0 - m) : m[DATA_W-1:0];
        return r;
    endfunction

    function automatic alu_out_t q24_sat(input longint v);
        return q24_clamp(v < 0, (v < 0) ? -v : v);
    endfunction

    function automatic alu_out_t q24_alu_predict(input fxq_alu_pkg::op_t op,
                                                 input logic [DATA_W-1:0] a_raw,
                                                 input logic [DATA_W-1:0] b_raw);
        alu_out_t    r;
        longint      sa;
        longint      sb;
        logic [63:0] ma;
        logic [63:0] mb;
        bit          neg;
        sa = $signed(a_raw);
        sb = $signed(b_raw);
        ma = (sa < 0) ? -sa : sa;
        mb = (sb < 0) ? -sb : sb;
        neg = (sa < 0) != (sb < 0);
        r = '0;
        r.status = fxq_alu_pkg::ST_OK;
        case (op)
            fxq_alu_pkg::OP_ADD:     r = q24_sat(sa + sb);
            fxq_alu_pkg::OP_SUB:     r = q24_sat(sa - sb);
            fxq_alu_pkg::OP_MUL:
                r = q24_clamp(neg, (ma * mb + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS);
            fxq_alu_pkg::OP_DIV: begin
                if (mb == 64'd0) begin
                    r.status = fxq_alu_pkg::ST_DIV_ZERO;
                end else begin
                    r = q24_clamp(neg, (64'd2 * (ma << FRAC_BITS) + mb) / (64'd2 * mb));
                end
            end
            fxq_alu_pkg::OP_GT:      r.truth = sa > sb;
            fxq_alu_pkg::OP_LT:      r.truth = sa < sb;
            fxq_alu_pkg::OP_LE:      r.truth = sa <= sb;
            fxq_alu_pkg::OP_GE:      r.truth = sa >= sb;
            fxq_alu_pkg::OP_EQ:      r.truth = sa == sb;
            fxq_alu_pkg::OP_NE:      r.truth = sa != sb;
            fxq_alu_pkg::OP_INC:     r = q24_sat(sa + 1);
            fxq_alu_pkg::OP_DEC:     r = q24_sat(sa - 1);
            fxq_alu_pkg::OP_MIN:     r.result = (sa > sb) ? b_raw : a_raw;
            fxq_alu_pkg::OP_MAX:     r.result = (sa > sb) ? a_raw : b_raw;
            fxq_alu_pkg::OP_TOINT:   r = q24_clamp(sa < 0, ma >> FRAC_BITS);
            fxq_alu_pkg::OP_FROMINT: r = q24_clamp(sa < 0, ma << FRAC_BITS);
        endcase
        return r;
    endfunction

    // Mostly no gap, sometimes a short one, rarely a long one.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [DATA_W-1:0] rand_operand();
        logic [DATA_W-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2: v = $urandom;
            3, 4:    v = DATA_W'($urandom_range(0, 8191)) - 32'd4096;
            5:       v = $urandom >> $urandom_range(0, 31);
            6:       v = DATA_W'($urandom_range(0, 63)) + 32'h007F_FFE0;  // fromint edge
            7:       v = Q_MAX - DATA_W'($urandom_range(0, 511));
            8: begin
                case ($urandom_range(0, 7))
                    0: v = '0;
                    1: v = Q_MIN;
                    2: v = Q_MAX;
                    3: v = Q_ONE;
                    4: v = -Q_ONE;
                    5: v = 32'd1;
                    6: v = 32'hFFFF_FFFF;
                    default: v = 32'd128;
                endcase
            end
            // whole numbers and exact halves
            default: v = (DATA_W'($urandom_range(0, 2047)) << FRAC_BITS)
                         | ($urandom_range(0, 1) ? 32'd128 : 32'd0);
        endcase
        if (v != Q_MIN && $urandom_range(0, 1)) v = -v;
        return v;
    endfunction

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        $display("mismatch: %s at result %0d, got %h want %h", what, results_seen, got, want);
        mismatch_count++;
    endtask

    task automatic add_row(input fxq_alu_pkg::op_t op, input logic [DATA_W-1:0] a,
                           input logic [DATA_W-1:0] b, input logic known,
                           input logic [DATA_W-1:0] res, input logic truth,
                           input fxq_alu_pkg::status_t st);
        dir_row_t row;
        row.op = op;
        row.a = a;
        row.b = b;
        row.known = known;
        row.want.result = res;
        row.want.truth = truth;
        row.want.status = st;
        directed_rows.push_back(row);
    endtask

    task automatic offer_item(input fxq_alu_pkg::op_t op, input logic [DATA_W-1:0] a,
                              input logic [DATA_W-1:0] b, input logic known,
                              input alu_out_t want);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {b, a};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_results.push_back(known ? want : q24_alu_predict(op, a, b));
        gap = calm ? 0 : idle_len();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic wait_all_results();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
    endtask

    // Receiver: random back-pressure, quiet stretches, one long hold-off.
    initial begin
        int stall;
        m_tready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (long_hold) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                long_hold = 1'b0;
            end else begin
                m_tready <= 1'b1;
                repeat (1 + (calm ? 40 : $urandom_range(0, 7))) @(posedge aclk);
                stall = calm ? 0 : idle_len();
                if (stall != 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
        end
    end

    always @(posedge aclk) begin : check_results
        alu_out_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected transaction", m_tdata[DATA_W-1:0], '0);
            end else begin
                want = expected_results.pop_front();
                if (m_tdata[DATA_W-1:0] !== want.result)
                    report_mismatch("result", m_tdata[DATA_W-1:0], want.result);
                if (m_tdata[DATA_W] !== want.truth)
                    report_mismatch("truth", DATA_W'(m_tdata[DATA_W]), DATA_W'(want.truth));
                if (m_tuser !== want.status)
                    report_mismatch("status", DATA_W'(m_tuser), DATA_W'(want.status));
                if (m_tdata[OUT_TDATA_W-1:DATA_W+1] !== '0)
                    report_mismatch("tdata pad", DATA_W'(m_tdata[OUT_TDATA_W-1:DATA_W+1]), '0);
            end
            results_seen++;
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL fixed_point_q24_8_alu");
            $finish;
        end
    end

    initial begin
        fxq_alu_pkg::op_t  op;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;

        // Saturation bounds, divide by zero, conversions, min/max and all comparisons.
        add_row(fxq_alu_pkg::OP_ADD, Q_MAX, 32'd1, 1'b1, Q_MAX, 1'b0,
                fxq_alu_pkg::ST_OVERFLOW);
        add_row(fxq_alu_pkg::OP_ADD, Q_MIN, 32'hFFFF_FFFF, 1'b1, Q_MIN, 1'b0,
                fxq_alu_pkg::ST_OVERFLOW);
        add_row(fxq_alu_pkg::OP_SUB, 32'd0, Q_MIN, 1'b1, Q_MAX, 1'b0,
                fxq_alu_pkg::ST_OVERFLOW);
        add_row(fxq_alu_pkg::OP_SUB, Q_MIN, 32'd1, 1'b1, Q_MIN, 1'b0,
                fxq_alu_pkg::ST_OVERFLOW);
        add_row(fxq_alu_pkg::OP_MUL, 32'd384, -32'd512, 1'b0, '0, 1'b0,
                fxq_alu_pkg::ST_OK);
        add_row(fxq_alu_pkg::OP_MUL, Q_MAX, Q_MAX, 1'b1, Q_MAX, 1'b0,
                fxq_alu_pkg::ST_OVERFLOW);
        add_row(fxq_alu_pkg::OP_MUL, Q_MIN, Q_MIN, 1'b1, Q_MAX, 1'b0,
                fxq_alu_pkg::ST_OVERFLOW);
        add_row(fxq_alu_pkg::OP_MUL, 32'hFFFF_FFFF, 32'd128, 1'b0, '0, 1'b0,
                fxq_alu_pkg::ST_OK);
        add_row(fxq_alu_pkg::OP_DIV, Q_ONE, 32'd0, 1'b1, '0, 1'b0,
                fxq_alu_pkg::ST_DIV_ZERO);
        add_row(fxq_alu_pkg::OP_DIV, Q_MIN, 32'd0, 1'b1, '0, 1'b0,
                fxq_alu_pkg::ST_DIV_ZERO);
        add_row(fxq_alu_pkg::OP_DIV, Q_MIN, -Q_ONE, 1'b1, Q_MAX, 1'b0,
                fxq_alu_pkg::ST_OVERFLOW);
        add_row(fxq_alu_pkg::OP_DIV, 32'd1, 32'd512, 1'b0, '0, 1'b0,
                fxq_alu_pkg::ST_OK);
        add_row(fxq_alu_pkg::OP_DIV, -32'd3, 32'd7, 1'b0, '0, 1'b0,
                fxq_alu_pkg::ST_OK);
        add_row(fxq_alu_pkg::OP_GT, Q_MAX, Q_MIN, 1'b1, '0, 1'b1, fxq_alu_pkg::ST_OK);
        add_row(fxq_alu_pkg::OP_LT, Q_MIN, Q_MAX, 1'b1, '0, 1'b1, fxq_alu_pkg::ST_OK);
        add_row(fxq_alu_pkg::OP_LE, 32'd5, 32'd5, 1'b1, '0, 1'b1, fxq_alu_pkg::ST_OK);
        add_row(fxq_alu_pkg::OP_GE, 32'hFFFF_FFFF, 32'd0, 1'b1, '0, 1'b0,
                fxq_alu_pkg::ST_OK);
        add_row(fxq_alu_pkg::OP_EQ, Q_MIN, Q_MIN, 1'b1, '0, 1'b1, fxq_alu_pkg::ST_OK);
        add_row(fxq_alu_pkg::OP_NE, Q_MAX, Q_MAX, 1'b1, '0, 1'b0, fxq_alu_pkg::ST_OK);
        add_row(fxq_alu_pkg::OP_INC, Q_MAX, 32'd0, 1'b1, Q_MAX, 1'b0,
                fxq_alu_pkg::ST_OVERFLOW);
        add_row(fxq_alu_pkg::OP_DEC, Q_MIN, Q_MAX, 1'b1, Q_MIN, 1'b0,
                fxq_alu_pkg::ST_OVERFLOW);
        add_row(fxq_alu_pkg::OP_MIN, Q_MIN, Q_MAX, 1'b1, Q_MIN, 1'b0, fxq_alu_pkg::ST_OK);
        add_row(fxq_alu_pkg::OP_MAX, Q_MIN, Q_MAX, 1'b1, Q_MAX, 1'b0, fxq_alu_pkg::ST_OK);
        add_row(fxq_alu_pkg::OP_TOINT, -32'd384, 32'd0, 1'b1, 32'hFFFF_FFFF, 1'b0,
                fxq_alu_pkg::ST_OK);
        add_row(fxq_alu_pkg::OP_TOINT, Q_MIN, 32'd0, 1'b1, 32'hFF80_0000, 1'b0,
                fxq_alu_pkg::ST_OK);
        add_row(fxq_alu_pkg::OP_FROMINT, 32'd8388608, 32'd0, 1'b1, Q_MAX, 1'b0,
                fxq_alu_pkg::ST_OVERFLOW);
        add_row(fxq_alu_pkg::OP_FROMINT, -32'd8388608, 32'd0, 1'b1, Q_MIN, 1'b0,
                fxq_alu_pkg::ST_OK);

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i])
            offer_item(directed_rows[i].op, directed_rows[i].a, directed_rows[i].b,
                       directed_rows[i].known, directed_rows[i].want);
        wait_all_results();

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            calm = (i % 300) >= 220;
            // long receiver hold-off while the sender keeps pushing
            if (i == 520) long_hold = 1'b1;
            if (i == 1100) wait_all_results();
            op = fxq_alu_pkg::op_t'($urandom_range(0, 15));
            a = rand_operand();
            b = rand_operand();
            if (op == fxq_alu_pkg::OP_DIV && $urandom_range(0, 19) == 0) b = '0;
            offer_item(op, a, b, 1'b0, '0);
        end
        wait_all_results();
        repeat (60) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("PASS fixed_point_q24_8_alu");
        end else begin
            $display("FAIL fixed_point_q24_8_alu");
        end
        $finish;
    end

endmodule
